// File: hw/rtl/eucra_pkg.sv
package eucra_pkg;

	// Field widths of the frame and result beats.
	localparam int ANGLE_W     = 13;
	localparam int SPEED_W     = 16;
	localparam int DELTA_W     = 14;
	localparam int TURNS_W     = 32;
	localparam int POS_W       = 45;
	localparam int ANGLE_Q10_W = 51;
	localparam int CALIB_W     = 8;
	localparam int FCOUNT_W    = 9;

	// Encoder geometry and angle scaling.
	localparam int COUNTS_PER_TURN   = 8192;
	localparam int HALF_TURN         = COUNTS_PER_TURN / 2;
	localparam int DEG_Q10_PER_COUNT = 45;

	// Calibration frame count after reset.
	localparam logic [CALIB_W-1:0] CALIB_RESET = 8'd5;

	typedef logic        [ANGLE_W-1:0]     angle_t;
	typedef logic signed [SPEED_W-1:0]     speed_t;
	typedef logic signed [DELTA_W-1:0]     delta_t;
	typedef logic signed [TURNS_W-1:0]     turns_t;
	typedef logic signed [POS_W-1:0]       pos_t;
	typedef logic signed [ANGLE_Q10_W-1:0] angle_q10_t;

	// Control from the frame pipeline to the delta ring.
	typedef struct packed {
		logic load;
		logic push;
	} ring_ctl_t;

endpackage

// File: hw/rtl/eucra_if.sv
// Frame channel: one encoder feedback frame per beat.
interface eucra_frame_if;
	logic                  valid;
	logic                  ready;
	eucra_pkg::angle_t     angle_reading;
	eucra_pkg::speed_t     speed_reading;

	modport source (output valid, angle_reading, speed_reading, input ready);
	modport sink (input valid, angle_reading, speed_reading, output ready);
endinterface

// Result channel: one unwrapped position result per beat.
interface eucra_result_if;
	logic                   valid;
	logic                   ready;
	logic                   calibrating;
	eucra_pkg::delta_t      step_delta;
	eucra_pkg::turns_t      turns;
	eucra_pkg::pos_t        total_position;
	eucra_pkg::angle_q10_t  angle_q10;
	eucra_pkg::delta_t      mean_delta;
	eucra_pkg::speed_t      speed_out;

	modport source (output valid, calibrating, step_delta, turns, total_position, angle_q10,
		mean_delta, speed_out, input ready);
	modport sink (input valid, calibrating, step_delta, turns, total_position, angle_q10,
		mean_delta, speed_out, output ready);
endinterface

// File: hw/rtl/eucra_ring.sv
module eucra_ring #(
	parameter int RING_DEPTH = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  eucra_pkg::ring_ctl_t ctl,
	input  eucra_pkg::delta_t    push_delta,
	output eucra_pkg::delta_t    old_delta
);

	localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

	logic [PTR_W-1:0]  ptr_q;
	logic              filled_q;
	eucra_pkg::delta_t mem [RING_DEPTH];
	eucra_pkg::delta_t rd_s1;
	logic              rd_valid_s1;

	// Write pointer and fill flag. Entries at or past the pointer hold data only
	// once the ring has wrapped, so one flag stands in for a clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			filled_q <= 1'b0;
		end else if (ctl.push) begin
			if (ptr_q == PTR_LAST) begin
				ptr_q    <= '0;
				filled_q <= 1'b1;
			end else begin
				ptr_q <= ptr_q + 1'b1;
			end
		end
	end

	// The read sees the entry before this beat overwrites it.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rd_s1 <= mem[ptr_q];
		end
		if (ctl.push) begin
			mem[ptr_q] <= push_delta;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else if (ctl.load) begin
			rd_valid_s1 <= filled_q;
		end
	end

	// An entry never written reads as cleared.
	assign old_delta = rd_valid_s1 ? rd_s1 : '0;

endmodule

// File: hw/rtl/encoder_unwrap_calib_rate_average.sv
// Multi-turn unwrap of a 13-bit absolute rotor encoder with a moving average of the
// per-frame angle change. The first calibration_frames frames after reset store their
// reading as zero bias; each later frame unwraps its change at half a turn, steps a
// 32-bit turn counter and pushes the change into a RING_DEPTH-entry ring whose mean,
// truncated toward zero, comes with every result. The block takes one frame per clock
// while the result side accepts, and returns its result through the stage 1, stage 2
// and output registers; the ring lives in a single memory with one read per frame and
// one write per later frame, and the average is a running sum divided by a reciprocal
// multiply. The ring starts cleared without any clearing pass, so frames are accepted
// right after reset. Write calibration_frames only while no frame is in flight.
module encoder_unwrap_calib_rate_average #(
	parameter int RING_DEPTH = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [eucra_pkg::CALIB_W-1:0]     cfg_wdata,
	eucra_frame_if.sink                       frame,
	eucra_result_if.source                    result
);

	localparam int CLOG_D = $clog2(RING_DEPTH);
	localparam int SUM_W  = eucra_pkg::DELTA_W + CLOG_D;
	localparam int MAG_W  = SUM_W - 1;
	localparam int DIV_K  = MAG_W + CLOG_D;
	localparam int PROD_W = MAG_W + DIV_K + 1;
	localparam logic [DIV_K:0] DIV_M =
		(DIV_K + 1)'(((64'd1 << DIV_K) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH));

	localparam int DIFF_W = eucra_pkg::ANGLE_W + 2;
	localparam logic signed [DIFF_W-1:0] HALF_S = DIFF_W'(eucra_pkg::HALF_TURN);
	localparam logic signed [DIFF_W-1:0] FULL_S = DIFF_W'(eucra_pkg::COUNTS_PER_TURN);
	localparam int REL_W = eucra_pkg::POS_W + 1;
	localparam logic signed [6:0] DEG_S = 7'(eucra_pkg::DEG_Q10_PER_COUNT);

	// Configuration and per-encoder state.
	logic [eucra_pkg::CALIB_W-1:0]  calib_frames_q;
	logic [eucra_pkg::FCOUNT_W-1:0] frame_count_q;
	eucra_pkg::angle_t              bias_q;
	eucra_pkg::angle_t              prev_q;
	eucra_pkg::turns_t              turn_q;
	logic signed [SUM_W-1:0]        sum_q;

	// Handshake.
	logic adv3, adv2, ld1, acc;

	// Frame stage.
	logic                    calib_now;
	logic signed [DIFF_W-1:0] diff;
	logic signed [DIFF_W-1:0] delta_raw;
	eucra_pkg::turns_t       turn_next;
	eucra_pkg::delta_t       delta_now;
	eucra_pkg::turns_t       turns_now;
	eucra_pkg::angle_t       bias_now;

	// Pipeline registers.
	logic                    valid_s1, valid_s2, valid_s3;
	logic                    calib_s1, calib_s2, calib_s3;
	eucra_pkg::delta_t       delta_s1, delta_s2, delta_s3;
	eucra_pkg::turns_t       turns_s1, turns_s2, turns_s3;
	eucra_pkg::angle_t       reading_s1;
	eucra_pkg::angle_t       bias_s1;
	eucra_pkg::speed_t       speed_s1, speed_s2, speed_s3;
	eucra_pkg::pos_t         pos_s2, pos_s3;
	eucra_pkg::angle_q10_t   angle_s2, angle_s3;
	logic [PROD_W-1:0]       prod_s2;
	logic                    neg_s2;
	eucra_pkg::delta_t       mean_s3;

	// Sum, divide and angle stage.
	eucra_pkg::ring_ctl_t    ring_ctl;
	eucra_pkg::delta_t       old_delta;
	logic signed [SUM_W-1:0] sum_next;
	logic [MAG_W-1:0]        mag;
	logic signed [REL_W-1:0] rel;
	logic signed [REL_W+6:0] angle_full;
	eucra_pkg::delta_t       quo;
	eucra_pkg::delta_t       mean_now;

	// Each stage loads when it is empty or its content moves on.
	assign adv3        = !valid_s3 || result.ready;
	assign adv2        = !valid_s2 || adv3;
	assign ld1         = !valid_s1 || adv2;
	assign frame.ready = ld1;
	assign acc         = frame.valid && ld1;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_frames_q <= eucra_pkg::CALIB_RESET;
		end else if (cfg_we) begin
			calib_frames_q <= cfg_wdata;
		end
	end

	// Calibration decision and half-turn unwrap.
	assign calib_now = frame_count_q < {1'b0, calib_frames_q};
	assign diff = $signed({2'b00, frame.angle_reading}) - $signed({2'b00, prev_q});

	always_comb begin
		priority if (diff < -HALF_S) begin
			turn_next = turn_q + 32'sd1;
			delta_raw = diff + FULL_S;
		end else if (diff > HALF_S) begin
			turn_next = turn_q - 32'sd1;
			delta_raw = diff - FULL_S;
		end else begin
			turn_next = turn_q;
			delta_raw = diff;
		end
	end

	assign delta_now = calib_now ? '0 : delta_raw[eucra_pkg::DELTA_W-1:0];
	assign turns_now = calib_now ? turn_q : turn_next;
	assign bias_now  = calib_now ? frame.angle_reading : bias_q;

	// Encoder state update on every frame beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= '0;
			bias_q        <= '0;
			prev_q        <= '0;
			turn_q        <= '0;
		end else if (acc) begin
			if (frame_count_q <= {1'b0, calib_frames_q}) begin
				frame_count_q <= frame_count_q + 1'b1;
			end
			bias_q <= bias_now;
			prev_q <= frame.angle_reading;
			turn_q <= turns_now;
		end
	end

	// Delta ring: read the outgoing entry and write the new delta in the same beat.
	assign ring_ctl.load = acc;
	assign ring_ctl.push = acc && !calib_now;

	eucra_ring #(
		.RING_DEPTH(RING_DEPTH)
	) u_ring (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ring_ctl),
		.push_delta (delta_now),
		.old_delta  (old_delta)
	);

	// Stage 1 registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ld1) begin
			valid_s1 <= frame.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			calib_s1   <= calib_now;
			delta_s1   <= delta_now;
			turns_s1   <= turns_now;
			reading_s1 <= frame.angle_reading;
			bias_s1    <= bias_now;
			speed_s1   <= frame.speed_reading;
		end
	end

	// Running sum of the ring: drop the outgoing entry, add the new one; a calibration frame holds it.
	always_comb begin
		if (calib_s1) begin
			sum_next = sum_q;
		end else begin
			sum_next = sum_q + SUM_W'(delta_s1) - SUM_W'(old_delta);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (valid_s1 && adv2) begin
			sum_q <= sum_next;
		end
	end

	// Magnitude for the reciprocal divide, and position relative to the bias.
	assign mag = sum_next[SUM_W-1] ? MAG_W'(-sum_next) : MAG_W'(sum_next);
	assign rel = $signed({turns_s1[eucra_pkg::TURNS_W-1], turns_s1, reading_s1})
		- $signed({(REL_W - eucra_pkg::ANGLE_W)'(0), bias_s1});
	assign angle_full = rel * DEG_S;

	// Stage 2 registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv2) begin
			calib_s2 <= calib_s1;
			delta_s2 <= delta_s1;
			turns_s2 <= turns_s1;
			pos_s2   <= {turns_s1, reading_s1};
			angle_s2 <= angle_full[eucra_pkg::ANGLE_Q10_W-1:0];
			prod_s2  <= PROD_W'(mag) * PROD_W'(DIV_M);
			neg_s2   <= sum_next[SUM_W-1];
			speed_s2 <= speed_s1;
		end
	end

	// Quotient toward zero.
	assign quo      = prod_s2[DIV_K +: eucra_pkg::DELTA_W];
	assign mean_now = neg_s2 ? -quo : quo;

	// Output registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && adv3) begin
			calib_s3 <= calib_s2;
			delta_s3 <= delta_s2;
			turns_s3 <= turns_s2;
			pos_s3   <= pos_s2;
			angle_s3 <= angle_s2;
			mean_s3  <= mean_now;
			speed_s3 <= speed_s2;
		end
	end

	assign result.valid          = valid_s3;
	assign result.calibrating    = calib_s3;
	assign result.step_delta     = delta_s3;
	assign result.turns          = turns_s3;
	assign result.total_position = pos_s3;
	assign result.angle_q10      = angle_s3;
	assign result.mean_delta     = mean_s3;
	assign result.speed_out      = speed_s3;

`ifndef SYNTHESIS
	// An unwrapped step never exceeds half a turn.
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.step_delta >= -14'sd4096 && result.step_delta <= 14'sd4096))
		else $error("unwrapped step beyond half a turn");

	// A calibration result carries no step.
	a_calib_step: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.calibrating) |-> (result.step_delta == '0))
		else $error("calibration result with nonzero step");

	// The ring mean stays within half a turn.
	a_mean_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.mean_delta >= -14'sd4096 && result.mean_delta <= 14'sd4096))
		else $error("ring mean out of range");

	// A calibration frame leaves the turn counter alone.
	a_calib_turns: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && calib_now) |=> (turn_q == $past(turn_q)))
		else $error("turn counter moved on a calibration frame");
`endif

endmodule
